// ===== hw/rtl/mm2h_pkg.sv =====
// Shared constants, command type and helpers for the Murmur2 64-bit stream hash.
package mm2h_pkg;

  // Murmur2 multiplier and shift distances.
  localparam logic [63:0] MulM       = 64'hc6a4a7935bd1e995;
  localparam int unsigned PremixShift = 47;
  localparam int unsigned FinShiftA   = 45;
  localparam int unsigned FinShiftB   = 47;

  // Command queue sizing between the front and back parts.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // One classified beat, as handed from the front part to the back part.
  typedef struct packed {
    logic        restart;      // first beat of a message: load seed and length
    logic        absorb;       // at least one valid byte to fold in
    logic        premix;       // full word that takes the key premix
    logic        last;         // finalise and emit a result
    logic [63:0] word;         // message word, masked to its valid bytes
    logic [31:0] total_length;
    logic [31:0] seed;
  } cmd_t;

endpackage

// ===== hw/rtl/mm2h_front.sv =====
// Front part: accepts input beats, tracks message framing and classifies each beat.
module mm2h_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wen,
  input  logic          cfg_wdata,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [63:0]   word,
  input  logic [3:0]    valid_bytes,
  input  logic          first,
  input  logic          last,
  input  logic [31:0]   total_length,
  input  logic [31:0]   seed,
  input  logic          q_full,
  output logic          q_push,
  output mm2h_pkg::cmd_t q_cmd
);
  import mm2h_pkg::*;

  logic       premix_words;
  logic       in_message;
  logic       accept;
  logic       keep;
  logic [3:0] nvalid;
  logic [63:0] masked;

  // Configuration register and message framing flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      premix_words <= 1'b1;
      in_message   <= 1'b0;
    end else begin
      if (cfg_wen) begin
        premix_words <= cfg_wdata;
      end
      if (accept && keep) begin
        in_message <= ~last;
      end
    end
  end

  assign in_ready = ~q_full;
  assign accept   = in_valid & in_ready;
  // Beats outside an open message are dropped unless they open one.
  assign keep     = first | in_message;
  assign q_push   = accept & keep;

  // Counts above eight are treated as a full word.
  assign nvalid = valid_bytes[3] ? 4'd8 : valid_bytes;

  // Keep only the valid low-order bytes of the word.
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      masked[8*b +: 8] = (4'(b) < nvalid) ? word[8*b +: 8] : 8'h00;
    end
  end

  always_comb begin
    q_cmd.restart      = first;
    q_cmd.absorb       = (nvalid != 4'd0);
    q_cmd.premix       = (nvalid == 4'd8) & premix_words;
    q_cmd.last         = last;
    q_cmd.word         = masked;
    q_cmd.total_length = total_length;
    q_cmd.seed         = seed;
  end

endmodule

// ===== hw/rtl/mm2h_cmd_queue.sv =====
// Small register queue of classified commands between the front and back parts.
module mm2h_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mm2h_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output mm2h_pkg::cmd_t head_cmd
);
  import mm2h_pkg::*;

  cmd_t             mem [QDepth];
  logic [QPtrW-1:0] wptr;
  logic [QPtrW-1:0] rptr;
  logic [QCntW-1:0] count;

  assign full       = (count == QCntW'(QDepth));
  assign head_valid = (count != '0);
  assign head_cmd   = mem[rptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPtrW'(QDepth - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPtrW'(QDepth - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/mm2h_mul.sv =====
// Multi-cycle unit giving the low 64 bits of an operand times the Murmur2 constant.
module mm2h_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  output logic        busy,
  output logic [63:0] prod
);
  import mm2h_pkg::*;

  localparam logic [31:0] MulLo = MulM[31:0];
  localparam logic [31:0] MulHi = MulM[63:32];

  logic [1:0]  step;
  logic [63:0] a_reg;
  logic [63:0] p0;
  logic [31:0] p1;
  logic [31:0] p2;
  logic [31:0] mx;
  logic [31:0] my;
  logic [63:0] pr;

  // One 32x32 product per cycle: low*low, low*high, high*low, then the sum.
  assign mx = (step == 2'd2) ? a_reg[63:32] : a_reg[31:0];
  assign my = (step == 2'd1) ? MulHi : MulLo;
  assign pr = mx * my;

  // Sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
    end else if (start) begin
      busy <= 1'b1;
      step <= 2'd0;
    end else if (busy) begin
      step <= step + 2'd1;
      if (step == 2'd3) begin
        busy <= 1'b0;
      end
    end
  end

  // Operand and partial products; the result holds until the next product replaces it.
  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
    end
    if (busy) begin
      unique case (step)
        2'd0: p0 <= pr;
        2'd1: p1 <= pr[31:0];
        2'd2: p2 <= pr[31:0];
        2'd3: prod <= p0 + {p1 + p2, 32'h0000_0000};
        default: p0 <= p0;
      endcase
    end
  end

endmodule

// ===== hw/rtl/mm2h_back.sv =====
// Back part: runs the hash recurrence, premix and finalisation for each queued command.
module mm2h_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  mm2h_pkg::cmd_t q_head,
  output logic           q_pop,
  output logic           mul_start,
  output logic [63:0]    mul_a,
  input  logic           mul_busy,
  input  logic [63:0]    mul_prod,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    hash
);
  import mm2h_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_INIT = 6'b000010,
    ST_PK1  = 6'b000100,
    ST_PK2  = 6'b001000,
    ST_HM   = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t      state;
  state_t      state_next;
  cmd_t        cur;
  cmd_t        cur_next;
  logic [63:0] h;
  logic [63:0] h_next;
  logic [63:0] k;
  logic [63:0] k_next;
  logic        out_valid_next;
  logic [31:0] hash_next;

  logic        dispatch;
  cmd_t        dc;
  logic [63:0] dh;
  logic [63:0] init_h;
  logic [63:0] hm_h;
  logic [63:0] fin_h;

  // Candidate hash values at the end of each multiplication.
  assign init_h = {32'h0000_0000, cur.seed} ^ mul_prod;
  assign hm_h   = mul_prod ^ k;
  assign fin_h  = mul_prod ^ (mul_prod >> FinShiftB);

  // Dispatch works from the queue head when idle, else from the held command.
  assign dc = (state == ST_IDLE) ? q_head : cur;
  assign dh = (state == ST_IDLE) ? h : init_h;

  // Sequencer.
  always_comb begin
    state_next     = state;
    cur_next       = cur;
    h_next         = h;
    k_next         = k;
    q_pop          = 1'b0;
    mul_start      = 1'b0;
    mul_a          = h;
    dispatch       = 1'b0;
    out_valid_next = out_valid & ~out_ready;
    hash_next      = hash;

    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          cur_next = q_head;
          if (q_head.restart) begin
            mul_start  = 1'b1;
            mul_a      = {32'h0000_0000, q_head.total_length};
            state_next = ST_INIT;
          end else begin
            dispatch = 1'b1;
          end
        end
      end
      ST_INIT: begin
        if (!mul_busy) begin
          h_next   = init_h;
          dispatch = 1'b1;
        end
      end
      ST_PK1: begin
        if (!mul_busy) begin
          mul_start  = 1'b1;
          mul_a      = mul_prod ^ (mul_prod >> PremixShift);
          state_next = ST_PK2;
        end
      end
      ST_PK2: begin
        if (!mul_busy) begin
          k_next     = mul_prod;
          mul_start  = 1'b1;
          mul_a      = h;
          state_next = ST_HM;
        end
      end
      ST_HM: begin
        if (!mul_busy) begin
          h_next = hm_h;
          if (cur.last) begin
            mul_start  = 1'b1;
            mul_a      = hm_h ^ (hm_h >> FinShiftA);
            state_next = ST_FIN;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        if (!mul_busy && (!out_valid || out_ready)) begin
          h_next         = fin_h;
          hash_next      = fin_h[31:0];
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    // Choose the first step of the absorb path for a command.
    if (dispatch) begin
      priority if (dc.premix) begin
        mul_start  = 1'b1;
        mul_a      = dc.word;
        state_next = ST_PK1;
      end else if (dc.absorb) begin
        k_next     = dc.word;
        mul_start  = 1'b1;
        mul_a      = dh;
        state_next = ST_HM;
      end else if (dc.last) begin
        mul_start  = 1'b1;
        mul_a      = dh ^ (dh >> FinShiftA);
        state_next = ST_FIN;
      end else begin
        state_next = ST_IDLE;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      h         <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      h         <= h_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur  <= cur_next;
    k    <= k_next;
    hash <= hash_next;
  end

endmodule

// ===== hw/rtl/murmur2_64_stream_hash_unit.sv =====
// Top level of the streaming Murmur2 64-bit hash unit.
// Hashes a byte message sent as little-endian 64-bit words, one beat per word, and returns the
// low 32 bits of the finalised hash on the last beat. Each beat first passes the front part,
// which drops beats outside a message, masks partial words and queues a command; the back part
// then works through it on one shared constant multiplier that forms each 64-bit product in
// steps (three 32x32 partial products, then one sum). A beat therefore takes from 0 to 5
// multiplications in the back part: one for the seed and length on a first beat, two for the
// premix of a full word, one for absorbing, and one for finalisation on a last beat.
// A two-entry command queue lets new beats be taken while earlier ones are still being hashed,
// and the result sits in an output register until taken. The premix_words register (reset 1)
// is written via cfg_wen and cfg_wdata by the user only while idle; the block does not check.
module murmur2_64_stream_hash_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] word,
  input  logic [3:0]  valid_bytes,
  input  logic        first,
  input  logic        last,
  input  logic [31:0] total_length,
  input  logic [31:0] seed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash
);
  import mm2h_pkg::*;

  logic        q_full;
  logic        q_push;
  cmd_t        q_cmd;
  logic        q_pop;
  logic        q_valid;
  cmd_t        q_head;
  logic        mul_start;
  logic [63:0] mul_a;
  logic        mul_busy;
  logic [63:0] mul_prod;

  // Front part: framing and classification.
  mm2h_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .word         (word),
    .valid_bytes  (valid_bytes),
    .first        (first),
    .last         (last),
    .total_length (total_length),
    .seed         (seed),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  // Command queue between the two parts.
  mm2h_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  // Shared constant multiplier.
  mm2h_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .busy  (mul_busy),
    .prod  (mul_prod)
  );

  // Back part: hash recurrence and result register.
  mm2h_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .mul_start (mul_start),
    .mul_a     (mul_a),
    .mul_busy  (mul_busy),
    .mul_prod  (mul_prod),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hash      (hash)
  );

`ifndef SYNTH
  // The multiplier is never restarted while a product is still being formed.
  a_mul_no_restart: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

  // The multiplier only becomes busy after a start request.
  a_mul_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(mul_busy) |-> $past(mul_start))
    else $error("multiplier busy without a start");

  // The queue never takes a command when it is full.
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command queue overflow");

  // Only a queued command can be popped.
  a_queue_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("command queue underflow");
`endif

endmodule

// ===== tb/tb_murmur2_64_stream_hash_unit.sv =====
// Self-checking testbench for the streaming Murmur2 64-bit hash unit.
module tb_murmur2_64_stream_hash_unit;
  import mm2h_pkg::*;

  localparam int unsigned CycleLimit  = 500000;
  // Room for two queued commands plus the one in progress.
  localparam int unsigned QuietCycles = 80;
  localparam int unsigned HoldCycles  = 400;

  // Tracks the running hash of the open message and the digests still owed.
  class digest_board;
    logic [63:0] acc;
    bit          open;
    bit          premix;
    logic [31:0] expected_digests[$];
    int unsigned errors;
    int unsigned digests;
    int unsigned taken;

    function new();
      acc     = '0;
      open    = 1'b0;
      premix  = 1'b1;
      errors  = 0;
      digests = 0;
      taken   = 0;
    endfunction

    function int unsigned pending();
      return expected_digests.size();
    endfunction

    // Fold one accepted beat into the running hash and queue a digest on a last beat.
    function void note_beat(logic [63:0] w, logic [3:0] nb, logic f, logic l,
                            logic [31:0] len, logic [31:0] sd);
      logic [63:0] h;
      logic [63:0] k;
      int unsigned n;
      if (f) begin
        acc  = {32'd0, sd} ^ ({32'd0, len} * MulM);
        open = 1'b1;
      end else if (!open) begin
        return;
      end
      taken++;
      n = (nb > 4'd8) ? 8 : int'(nb);
      h = acc;
      if (n == 8) begin
        k = w;
        if (premix) begin
          k = k * MulM;
          k = k ^ (k >> PremixShift);
          k = k * MulM;
        end
        h = (h * MulM) ^ k;
      end else if (n > 0) begin
        h = (h * MulM) ^ (w & ((64'd1 << (8 * n)) - 64'd1));
      end
      if (!l) begin
        acc = h;
        return;
      end
      h = h ^ (h >> FinShiftA);
      h = h * MulM;
      h = h ^ (h >> FinShiftB);
      acc  = h;
      open = 1'b0;
      expected_digests.push_back(h[31:0]);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 50) $display("MISMATCH: %s", what);
    endtask

    // Compare one delivered digest with the oldest one owed.
    task check_digest(logic [31:0] got);
      logic [31:0] want;
      if (expected_digests.size() == 0) begin
        report($sformatf("digest %h arrived with none expected", got));
        return;
      end
      want = expected_digests.pop_front();
      digests++;
      if (got !== want) report($sformatf("digest %h, expected %h", got, want));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] word = '0;
  logic [3:0]  valid_bytes = '0;
  logic        first = 1'b0;
  logic        last = 1'b0;
  logic [31:0] total_length = '0;
  logic [31:0] seed = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] hash;

  digest_board sb;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  int unsigned beats_in = 0;

  murmur2_64_stream_hash_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .word        (word),
    .valid_bytes (valid_bytes),
    .first       (first),
    .last        (last),
    .total_length(total_length),
    .seed        (seed),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hash        (hash)
  );

  always #2 clk = ~clk;

  // Give up well past the slowest correct run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off when requested.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= !(idle_on && $urandom_range(99) < 21);
    end
  end

  // Every digest beat taken is checked against the predicted one.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_digest(hash);
  end

  // Offer one beat from a falling edge and hold it until accepted.
  task automatic send_beat(logic [63:0] w, logic [3:0] nb, logic f, logic l,
                           logic [31:0] len, logic [31:0] sd);
    while (idle_on && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    word         <= w;
    valid_bytes  <= nb;
    first        <= f;
    last         <= l;
    total_length <= len;
    seed         <= sd;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(w, nb, f, l, len, sd);
    beats_in++;
    @(negedge clk);
  endtask

  // Stop offering and wait until every digest is in and the back part has gone quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (QuietCycles) @(negedge clk);
  endtask

  task automatic write_premix(bit v);
    wait_idle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    sb.premix = v;
  endtask

  function automatic logic [63:0] pick64();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // A well-formed message: full words, then a tail of 0 to 8 bytes on the last beat.
  task automatic send_message();
    int unsigned nw;
    int unsigned tail;
    int unsigned i;
    logic [31:0] len;
    logic [31:0] sd;
    nw   = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    tail = $urandom_range(8);
    len  = ($urandom_range(9) == 0) ? pick32() : 32'(8 * (nw - 1) + tail);
    sd   = pick32();
    for (i = 0; i < nw; i++) begin
      if (i == 0) send_beat(pick64(), (nw == 1) ? 4'(tail) : 4'd8, 1'b1, nw == 1, len, sd);
      else send_beat(pick64(), (i == nw - 1) ? 4'(tail) : 4'd8, 1'b0, i == nw - 1,
                     pick32(), pick32());
    end
  endtask

  // Malformed traffic: raw beats, abandoned messages, stray beats and early tails.
  task automatic send_noise();
    case ($urandom_range(3))
      0: send_beat(pick64(), 4'($urandom_range(15)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), pick32(), pick32());
      1: begin
        send_beat(pick64(), 4'd8, 1'b1, 1'b0, pick32(), pick32());
        if ($urandom_range(1)) send_beat(pick64(), 4'd8, 1'b0, 1'b0, pick32(), pick32());
      end
      2: send_beat(pick64(), 4'($urandom_range(15)), 1'b0, 1'b1, pick32(), pick32());
      default: begin
        send_beat(pick64(), 4'd8, 1'b1, 1'b0, pick32(), pick32());
        send_beat(pick64(), 4'($urandom_range(1, 7)), 1'b0, 1'b0, pick32(), pick32());
        send_beat(pick64(), 4'($urandom_range(15)), 1'b0, 1'b1, pick32(), pick32());
      end
    endcase
  endtask

  task automatic run_random(int unsigned count);
    int unsigned goal;
    goal = sb.taken + count;
    while (sb.taken < goal) begin
      if ($urandom_range(99) < 15) send_noise();
      else send_message();
    end
  endtask

  // Hand-picked corner cases, run once for each premix setting.
  task automatic run_directed();
    // Empty message, then single beats at the field extremes.
    send_beat('1, 4'd0, 1'b1, 1'b1, 32'd0, 32'd0);
    send_beat('1, 4'd8, 1'b1, 1'b1, 32'd8, '1);
    send_beat('0, 4'd8, 1'b1, 1'b1, '1, '1);
    send_beat('1, 4'd1, 1'b1, 1'b1, '1, 32'd0);
    send_beat(64'h0123456789abcdef, 4'd7, 1'b1, 1'b1, 32'd7, 32'h9747b28c);
    // Valid byte count above eight counts as a full word.
    send_beat('1, 4'd15, 1'b1, 1'b1, 32'd8, 32'h5a5a5a5a);
    send_beat(64'h8000000000000001, 4'd9, 1'b1, 1'b1, 32'd8, 32'h1);
    // Stray beats outside a message are dropped, even with last set.
    send_beat('1, 4'd8, 1'b0, 1'b1, '1, '1);
    send_beat('1, 4'd3, 1'b0, 1'b0, '1, '1);
    // Partial word mid-message, then a partial tail.
    send_beat(64'hfedcba9876543210, 4'd8, 1'b1, 1'b0, 32'd16, 32'hdeadbeef);
    send_beat('1, 4'd3, 1'b0, 1'b0, '0, '0);
    send_beat('1, 4'd5, 1'b0, 1'b1, '1, '1);
    // A new first beat abandons the open message without a digest.
    send_beat(pick64(), 4'd8, 1'b1, 1'b0, 32'd24, 32'h12345678);
    send_beat(pick64(), 4'd8, 1'b0, 1'b0, '0, '0);
    send_beat(pick64(), 4'd8, 1'b1, 1'b0, 32'd9, 32'h87654321);
    send_beat(pick64(), 4'd1, 1'b0, 1'b1, '0, '0);
    // Zero-byte tail after a full word, with a length that does not match.
    send_beat(pick64(), 4'd8, 1'b1, 1'b0, 32'd1000, 32'h0);
    send_beat(pick64(), 4'd0, 1'b0, 1'b1, '0, '0);
  endtask

  initial begin
    sb = new();
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    write_premix(1'b1);
    run_directed();
    write_premix(1'b0);
    run_directed();

    // Premix on, random idling on both sides.
    write_premix(1'b1);
    run_random(270);

    // Premix off, a long stretch without any idling.
    write_premix(1'b0);
    idle_on = 1'b0;
    run_random(200);
    idle_on = 1'b1;

    // Premix on; the result side holds off while beats keep coming.
    write_premix(1'b1);
    hold_req = 1'b1;
    repeat (40) send_message();
    run_random(170);

    // Premix off; the sender stops midway until every digest has come back.
    write_premix(1'b0);
    run_random(100);
    wait_idle();
    run_random(100);

    wait_idle();
    $display("Covered %0d beats, %0d inside messages, and %0d digests checked,",
             beats_in, sb.taken, sb.digests);
    $display("with premix on and off, malformed framing, stalls and a long hold-off.");
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
